// File: hdl/rssi_presence_qualifier_assert.svh
// Assertion macros shared by the presence qualifier RTL.
// Included by name; depends on nothing else.
`ifndef RSSI_PRESENCE_QUALIFIER_ASSERT_SVH
`define RSSI_PRESENCE_QUALIFIER_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define RPQ_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpq assertion failed: same-cycle implication");

// Next-cycle implication, held off during reset.
`define RPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpq assertion failed: next-cycle implication");

`endif

// File: hdl/rpq_pkg.sv
// Shared types and constants of the presence qualifier.
// No dependencies; used by the top level, rpq_window and rpq_qualify.
package rpq_pkg;

  localparam int WINDOW_DEPTH_DEF = 8;

  localparam logic signed [7:0] NORMAL_THR_RST = -8'sd70;
  localparam logic signed [7:0] HIGH_THR_RST   = -8'sd50;
  localparam logic [7:0]        CONFIRM_RST    = 8'd3;
  localparam logic [7:0]        MAX_OOR_RST    = 8'd5;

  localparam logic [7:0]        COUNT_MAX      = 8'hFF;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_NORMAL_THR  = 2'd0,
    REG_HIGH_THR    = 2'd1,
    REG_CONFIRM     = 2'd2,
    REG_MAX_OOR     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [7:0] normal_threshold;
    logic signed [7:0] high_threshold;
    logic [7:0]        confirm_needed;
    logic [7:0]        max_out_of_range;
  } cfg_t;

  typedef struct packed {
    logic in_range;
    logic has_chance;
    logic rechecking;
  } result_t;

endpackage

// File: hdl/rpq_if.sv
// Valid/ready channel interfaces for sample items and status results.
// Depends on nothing.
interface rpq_item_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] sample;
  logic              door_closed;

  modport source (output valid, output sample, output door_closed, input ready);
  modport sink   (input valid, input sample, input door_closed, output ready);
endinterface

interface rpq_result_if;
  logic valid;
  logic ready;
  logic in_range;
  logic has_chance;
  logic rechecking;

  modport source (output valid, output in_range, output has_chance, output rechecking,
                  input ready);
  modport sink   (input valid, input in_range, input has_chance, input rechecking,
                  output ready);
endinterface

// File: hdl/rssi_presence_qualifier.sv
// Top level of the presence qualifier: channels, config registers, input and output stages.
// Depends on rpq_pkg, rpq_if, rpq_window and rpq_qualify.
//
// Usage:
//   item   : valid/ready channel carrying a signed 8-bit sample and a door_closed flag.
//   result : valid/ready channel carrying in_range, has_chance and rechecking,
//            exactly one result per item, in order.
//   cfg_we/cfg_index/cfg_data : register write port, one write per cycle with cfg_we
//            high; write only while no item is in flight.
// Pipeline: an item passes the input register, then the result register, before
//   its result is presented (two register stages).
// Throughput: one item per cycle while result.ready is high; presence state updates
//   once per item in a single pass of compare and counter logic between the two registers.
// Reset (rst, synchronous): thresholds and counts return to their defaults, the
//   sample window is marked empty, recheck, seen and counters clear, both stages empty.
// Stall: while result.ready is low the result register holds; the input register
//   still takes one more item, after which item.ready drops until the result moves.
module rssi_presence_qualifier #(
  parameter int WindowDepth = rpq_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  rpq_item_if.sink            item,
  rpq_result_if.source        result,
  input  logic                cfg_we,
  input  rpq_pkg::cfg_reg_t   cfg_index,
  input  logic [7:0]          cfg_data
);

  rpq_pkg::cfg_t     cfg;
  logic              in_valid;
  logic signed [7:0] in_sample;
  logic              in_door;
  logic              out_valid;
  rpq_pkg::result_t  out_res;
  rpq_pkg::result_t  res_comb;
  logic              window_bad;
  logic              advance;
  logic              take;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.normal_threshold <= rpq_pkg::NORMAL_THR_RST;
      cfg.high_threshold   <= rpq_pkg::HIGH_THR_RST;
      cfg.confirm_needed   <= rpq_pkg::CONFIRM_RST;
      cfg.max_out_of_range <= rpq_pkg::MAX_OOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rpq_pkg::REG_NORMAL_THR: cfg.normal_threshold <= cfg_data;
        rpq_pkg::REG_HIGH_THR:   cfg.high_threshold   <= cfg_data;
        rpq_pkg::REG_CONFIRM:    cfg.confirm_needed   <= cfg_data;
        rpq_pkg::REG_MAX_OOR:    cfg.max_out_of_range <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance when the input stage is full and the result stage can take it
  assign advance    = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || advance;
  assign take       = item.valid && item.ready;

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_sample <= item.sample;
      in_door   <= item.door_closed;
    end
  end

  rpq_window #(
    .WindowDepth (WindowDepth)
  ) u_window (
    .clk              (clk),
    .rst              (rst),
    .push             (advance),
    .sample           (in_sample),
    .normal_threshold (cfg.normal_threshold),
    .window_bad       (window_bad)
  );

  rpq_qualify u_qualify (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .sample      (in_sample),
    .door_closed (in_door),
    .window_bad  (window_bad),
    .cfg         (cfg),
    .result      (res_comb)
  );

  // Result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_comb;
    end
  end

  assign result.valid      = out_valid;
  assign result.in_range   = out_res.in_range;
  assign result.has_chance = out_res.has_chance;
  assign result.rechecking = out_res.rechecking;

endmodule

// File: hdl/rpq_window.sv
// Sample history: shift line of recent samples with fill count and bad-window compare.
// Depends on rpq_pkg.
module rpq_window #(
  parameter int WindowDepth = rpq_pkg::WINDOW_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic signed [7:0] sample,
  input  logic signed [7:0] normal_threshold,
  output logic              window_bad
);

  localparam int FillW = $clog2(WindowDepth + 1);
  localparam logic [FillW-1:0] FillFull = FillW'(WindowDepth);

  logic signed [7:0] window [WindowDepth];
  logic [FillW-1:0]  fill;
  logic [WindowDepth-1:0] below;

  // Shift in the new sample on each transfer
  always_ff @(posedge clk) begin
    if (push) begin
      window[0] <= sample;
      for (int i = 1; i < WindowDepth; i++) begin
        window[i] <= window[i-1];
      end
    end
  end

  // Count valid entries, saturate when full
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (push && (fill != FillFull)) begin
      fill <= fill + FillW'(1);
    end
  end

  // Compare every stored sample with the threshold in parallel
  always_comb begin
    for (int i = 0; i < WindowDepth; i++) begin
      below[i] = window[i] < normal_threshold;
    end
  end

  assign window_bad = (fill == FillFull) && (&below);

endmodule

// File: hdl/rpq_qualify.sv
// Presence state: recheck flag, confirm count, seen flag and weak count, plus result logic.
// Depends on rpq_pkg and rssi_presence_qualifier_assert.svh.
`include "rssi_presence_qualifier_assert.svh"

module rpq_qualify (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic signed [7:0] sample,
  input  logic              door_closed,
  input  logic              window_bad,
  input  rpq_pkg::cfg_t     cfg,
  output rpq_pkg::result_t  result
);

  logic       recheck_pending, recheck_pending_next;
  logic [7:0] confirm_count, confirm_count_next;
  logic       seen_in_range, seen_in_range_next;
  logic [7:0] weak_count, weak_count_next;

  logic       good;
  logic       high;
  logic       start_recheck;
  logic [7:0] confirm_inc;
  logic [7:0] weak_inc;

  assign good = sample >= cfg.normal_threshold;
  assign high = sample >= cfg.high_threshold;
  assign start_recheck = door_closed && window_bad && !high;

  assign confirm_inc = (confirm_count == rpq_pkg::COUNT_MAX) ? confirm_count
                                                             : confirm_count + 8'd1;
  assign weak_inc    = (weak_count == rpq_pkg::COUNT_MAX) ? weak_count
                                                          : weak_count + 8'd1;

  // Next state for one item
  always_comb begin
    recheck_pending_next = recheck_pending;
    confirm_count_next   = confirm_count;
    seen_in_range_next   = seen_in_range;
    weak_count_next      = weak_count;
    if (good) begin
      if (recheck_pending) begin
        confirm_count_next = confirm_inc;
        if ((confirm_inc >= cfg.confirm_needed) || high) begin
          recheck_pending_next = 1'b0;
          confirm_count_next   = 8'd0;
          seen_in_range_next   = 1'b1;
          weak_count_next      = 8'd0;
        end
      end else if (start_recheck) begin
        recheck_pending_next = 1'b1;
        confirm_count_next   = 8'd1;
      end else begin
        seen_in_range_next = 1'b1;
        weak_count_next    = 8'd0;
      end
    end else begin
      // Weak sample uses up a chance and drops any recheck
      if (seen_in_range) begin
        weak_count_next = weak_inc;
        if (weak_inc >= cfg.max_out_of_range) begin
          seen_in_range_next = 1'b0;
          weak_count_next    = 8'd0;
        end
      end
      recheck_pending_next = 1'b0;
      confirm_count_next   = 8'd0;
    end
  end

  // Hold state between transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      recheck_pending <= 1'b0;
      confirm_count   <= 8'd0;
      seen_in_range   <= 1'b0;
      weak_count      <= 8'd0;
    end else if (step) begin
      recheck_pending <= recheck_pending_next;
      confirm_count   <= confirm_count_next;
      seen_in_range   <= seen_in_range_next;
      weak_count      <= weak_count_next;
    end
  end

  // Status from the state after this item
  assign result.in_range   = good && !recheck_pending_next;
  assign result.has_chance = !recheck_pending_next && seen_in_range_next &&
                             (weak_count_next <= cfg.max_out_of_range);
  assign result.rechecking = recheck_pending_next;

  `RPQ_ASSERT_IMPLIES(a_recheck_count, clk, rst, recheck_pending, confirm_count != 8'd0)
  `RPQ_ASSERT_IMPLIES(a_unseen_no_weak, clk, rst, !seen_in_range, weak_count == 8'd0)
  `RPQ_ASSERT_NEXT(a_weak_drops_recheck, clk, rst, step && !good, !recheck_pending && (confirm_count == 8'd0))
  `RPQ_ASSERT_NEXT(a_plain_good_seen, clk, rst, step && good && !recheck_pending && !start_recheck, seen_in_range && (weak_count == 8'd0))

endmodule
